/* rtl/assert_macros.svh */
// Assertion helper macros for the ring FIFO block.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`endif

/* rtl/brf_pkg.sv */
// Shared types, constants and helpers for the ring FIFO block.
// No dependencies; imported by controller, datapath and top level.
package brf_pkg;

  localparam int CAPACITY = 1024;
  localparam int ELEM_W   = 32;
  localparam int MAX_BURST = 64;

  // fixed field widths of the request and result
  localparam int OP_W    = 2;
  localparam int COUNT_W = 7;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 32;
  localparam int MOVED_W = 7;
  localparam int FILL_W  = 11;

  localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
  localparam logic [PTR_W:0]   PTR_CAP  = (PTR_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(CAPACITY);
  localparam logic [CMP_W-1:0] CMP_BURST = CMP_W'(MAX_BURST);

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_DROP  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [COUNT_W-1:0] count;
    logic [IN_W-1:0]    element_in;
  } req_t;

  typedef struct packed {
    logic [OUT_W-1:0]   element_out;
    logic               element_valid;
    logic               last;
    logic [MOVED_W-1:0] moved;
    logic [FILL_W-1:0]  fill_level;
    logic [FILL_W-1:0]  space_left;
    logic               empty_res;
    logic               full_res;
  } res_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_REPORT,
    ACT_WRITE,
    ACT_POP,
    ACT_DROP,
    ACT_CLEAR
  } act_t;

  typedef struct packed {
    act_t               act;
    logic [MOVED_W-1:0] moved;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [MOVED_W-1:0] n_clamp;
    logic               full;
  } stat_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
  endfunction

endpackage

/* rtl/brf_ctrl.sv */
// Sequencer for the ring FIFO: decodes requests and steps read bursts.
// Depends on brf_pkg.
module brf_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [brf_pkg::OP_W-1:0]       opcode,
  input  brf_pkg::stat_t                 stat,
  output brf_pkg::cmd_t                  cmd,
  output logic                           busy
);
  import brf_pkg::*;

  state_t             state, state_next;
  logic [MOVED_W-1:0] remain, remain_next;
  logic [MOVED_W-1:0] burst, burst_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      remain <= '0;
      burst  <= '0;
    end else begin
      state  <= state_next;
      remain <= remain_next;
      burst  <= burst_next;
    end
  end

  always_comb begin
    state_next  = state;
    remain_next = remain;
    burst_next  = burst;
    cmd.act     = ACT_NONE;
    cmd.moved   = '0;
    cmd.last    = 1'b1;
    busy        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (opcode)
            OP_WRITE: begin
              cmd.act   = stat.full ? ACT_REPORT : ACT_WRITE;
              cmd.moved = stat.full ? '0 : MOVED_W'(1);
            end
            OP_READ: begin
              if (stat.n_clamp == '0) begin
                cmd.act = ACT_REPORT;
              end else begin
                cmd.act     = ACT_POP;
                cmd.moved   = stat.n_clamp;
                cmd.last    = (stat.n_clamp == MOVED_W'(1));
                burst_next  = stat.n_clamp;
                remain_next = stat.n_clamp - 1'b1;
                if (stat.n_clamp != MOVED_W'(1)) state_next = ST_READ;
              end
            end
            OP_DROP: begin
              cmd.act   = ACT_DROP;
              cmd.moved = stat.n_clamp;
            end
            OP_CLEAR: begin
              cmd.act = ACT_CLEAR;
            end
          endcase
        end
      end
      ST_READ: begin
        busy        = 1'b1;
        cmd.act     = ACT_POP;
        cmd.moved   = burst;
        cmd.last    = (remain == MOVED_W'(1));
        remain_next = remain - 1'b1;
        if (remain == MOVED_W'(1)) state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/brf_datapath.sv */
// Ring FIFO datapath: element memory, head/tail pointers, fill count, result regs.
// Depends on brf_pkg; driven by brf_ctrl commands.
module brf_datapath (
  input  logic           clk,
  input  logic           rst,
  input  brf_pkg::req_t  req,
  input  brf_pkg::cmd_t  cmd,
  output brf_pkg::stat_t stat,
  output logic           strobe,
  output brf_pkg::res_t  res
);
  import brf_pkg::*;

  logic [ELEM_W-1:0] mem [CAPACITY];
  logic [ELEM_W-1:0] rdata;

  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  logic               elem_valid;
  logic               last;
  logic [MOVED_W-1:0] moved;

  logic [CMP_W-1:0] req_n, cnt_w, n_min;
  logic [PTR_W:0]   head_sum;
  logic [CNT_W-1:0] space;

  // clamp: min(count, stored, burst limit)
  always_comb begin
    req_n = CMP_W'(req.count);
    cnt_w = CMP_W'(cnt);
    n_min = (req_n > cnt_w) ? cnt_w : req_n;
    if (n_min > CMP_BURST) n_min = CMP_BURST;
    stat.n_clamp = MOVED_W'(n_min);
    stat.full    = (cnt >= CNT_CAP);
  end

  // drop advance; n never exceeds the fill count, so one wrap suffices
  always_comb begin
    head_sum = {1'b0, head} + (PTR_W + 1)'(cmd.moved);
    if (head_sum >= PTR_CAP) head_sum = head_sum - PTR_CAP;
  end

  always_comb begin
    head_next = head;
    tail_next = tail;
    cnt_next  = cnt;
    case (cmd.act)
      ACT_WRITE: begin
        tail_next = next_slot(tail);
        cnt_next  = cnt + 1'b1;
      end
      ACT_POP: begin
        head_next = next_slot(head);
        cnt_next  = cnt - 1'b1;
      end
      ACT_DROP: begin
        head_next = head_sum[PTR_W-1:0];
        cnt_next  = cnt - CNT_W'(cmd.moved);
      end
      ACT_CLEAR: begin
        head_next = '0;
        tail_next = '0;
        cnt_next  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.act == ACT_WRITE) mem[tail] <= ELEM_W'(req.element_in);
    if (cmd.act == ACT_POP) rdata <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      head   <= head_next;
      tail   <= tail_next;
      cnt    <= cnt_next;
      strobe <= (cmd.act != ACT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    elem_valid <= (cmd.act == ACT_POP);
    last       <= cmd.last;
    moved      <= cmd.moved;
  end

  // cnt already holds the level after the op that produced this strobe
  assign space = CNT_CAP - cnt;

  always_comb begin
    res.element_out   = elem_valid ? OUT_W'(rdata) : '0;
    res.element_valid = elem_valid;
    res.last          = last;
    res.moved         = moved;
    res.fill_level    = FILL_W'(cnt);
    res.space_left    = FILL_W'(space);
    res.empty_res     = (cnt == '0);
    res.full_res      = (cnt >= CNT_CAP);
  end

endmodule

/* rtl/bulk_ring_fifo_top.sv */
// Top level of the ring FIFO block: controller plus datapath.
// Depends on brf_pkg, brf_ctrl, brf_datapath and assert_macros.svh.
//
// A request is taken when start is high and busy is low. Each result shows on
// res for one cycle with strobe high and cannot be held off. Write, drop,
// clear, a refused write and an empty read give one result in the cycle after
// the request, and busy stays low, so a new request may follow every cycle. A
// read of n elements (n clamped to the fill level and to 64) gives n results back
// to back starting the cycle after the request, one element per cycle through the
// single memory port with registered read data; busy is high while the rest of the
// burst is stepped.
`include "assert_macros.svh"

module bulk_ring_fifo_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  brf_pkg::req_t req,
  output logic          strobe,
  output brf_pkg::res_t res
);
  import brf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  brf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (req.opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  brf_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .stat   (stat),
    .strobe (strobe),
    .res    (res)
  );

  // every result traces back to a request or a burst step
  `ASSERT_CLK(a_strobe_cause, clk, rst, strobe |-> ($past(start && !busy) || $past(busy)), "result without request")
  // a burst in progress always has a non-final result showing
  `ASSERT_CLK(a_busy_burst, clk, rst, busy |-> (strobe && !res.last && res.element_valid), "burst gap")
  // non-final results come only from reads and are followed without a gap
  `ASSERT_CLK(a_burst_cont, clk, rst, (strobe && !res.last) |=> (strobe && res.element_valid), "burst broken")
  // level and free space always add up to the capacity
  `ASSERT_CLK(a_level_sum, clk, rst, strobe |-> (FILL_W'(res.fill_level + res.space_left) == FILL_W'(CAPACITY)), "level mismatch")

endmodule
